FILE: rtl/gbs_pkg.sv
// gbs_pkg: shared constants, register indexes and queue entry type for the
// grid bilinear sampler. No dependencies.
package gbs_pkg;

   localparam int MAX_COLS   = 256;
   localparam int MAX_ROWS   = 256;
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int SIZE_W     = 9;
   localparam int FRAC_W     = 16;
   localparam int COORD_W    = 40;
   localparam int RECIP_W    = 32;
   localparam int ELEV_W     = 24;
   localparam int IDX_W      = COL_W + FRAC_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_EAST  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_NORTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CPM_X        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CPM_Y        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 3'd5;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              cmd;
      logic [COL_W-1:0]  x0;
      logic [COL_W-1:0]  x1;
      logic [ROW_W-1:0]  y0;
      logic [ROW_W-1:0]  y1;
      logic [FRAC_W-1:0] tx;
      logic [FRAC_W-1:0] ty;
      logic [ELEV_W-1:0] elev;
   } gbs_entry_type;

endpackage

FILE: rtl/gbs_queue.sv
// gbs_queue: short FIFO of classified words between front and back.
// Depends on gbs_pkg.
module gbs_queue import gbs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gbs_entry_type     push_entry,
   input  logic              pop,
   output gbs_entry_type     head,
   output logic [QCNT_W-1:0] count
);

   gbs_entry_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, rptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + QPTR_W'(1);
         if (pop) rptr_ff <= rptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_entry;
   end

   assign head  = mem_ff[rptr_ff];
   assign count = count_ff;

endmodule

FILE: rtl/gbs_front.sv
// gbs_front: configuration registers, input acceptance and the clamped
// fractional index pipeline. Depends on gbs_pkg.
module gbs_front import gbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_cmd,
   input  logic [COL_W-1:0]      req_write_col,
   input  logic [ROW_W-1:0]      req_write_row,
   input  logic [ELEV_W-1:0]     req_elevation_in,
   input  logic [COORD_W-1:0]    req_query_east,
   input  logic [COORD_W-1:0]    req_query_north,
   input  logic [QCNT_W-1:0]     queue_count,
   output logic                  queue_push,
   output gbs_entry_type         queue_entry
);

   localparam int DIFF_W = COORD_W + 1;
   localparam int LO_W   = DIFF_W / 2;
   localparam int HI_W   = DIFF_W - LO_W;
   localparam int PH_W   = HI_W + RECIP_W;
   localparam int PL_W   = LO_W + RECIP_W;
   localparam int TOT_W  = DIFF_W + RECIP_W;
   localparam int SHIFT  = 32 - FRAC_W;

   logic [COORD_W-1:0] origin_east_ff, origin_north_ff;
   logic [RECIP_W-1:0] cpm_x_ff, cpm_y_ff;
   logic [SIZE_W-1:0]  grid_cols_ff, grid_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_east_ff  <= '0;
         origin_north_ff <= '0;
         cpm_x_ff        <= RECIP_W'(32'h0100_0000);
         cpm_y_ff        <= RECIP_W'(32'h0100_0000);
         grid_cols_ff    <= SIZE_W'(MAX_COLS);
         grid_rows_ff    <= SIZE_W'(MAX_ROWS);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ORIGIN_EAST:  origin_east_ff  <= csr_write_data[COORD_W-1:0];
            CSR_ORIGIN_NORTH: origin_north_ff <= csr_write_data[COORD_W-1:0];
            CSR_CPM_X:        cpm_x_ff        <= csr_write_data[RECIP_W-1:0];
            CSR_CPM_Y:        cpm_y_ff        <= csr_write_data[RECIP_W-1:0];
            CSR_GRID_COLS:    grid_cols_ff    <= csr_write_data[SIZE_W-1:0];
            CSR_GRID_ROWS:    grid_rows_ff    <= csr_write_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // last usable column / row
   logic [COL_W-1:0] cols_m1;
   logic [ROW_W-1:0] rows_m1;
   always_comb begin
      if (grid_cols_ff == '0) cols_m1 = '0;
      else if (grid_cols_ff > SIZE_W'(MAX_COLS)) cols_m1 = COL_W'(MAX_COLS - 1);
      else cols_m1 = COL_W'(grid_cols_ff - SIZE_W'(1));
      if (grid_rows_ff == '0) rows_m1 = '0;
      else if (grid_rows_ff > SIZE_W'(MAX_ROWS)) rows_m1 = ROW_W'(MAX_ROWS - 1);
      else rows_m1 = ROW_W'(grid_rows_ff - SIZE_W'(1));
   end

   logic accept;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [QCNT_W:0] credit_used;

   assign credit_used = {1'b0, queue_count} + (QCNT_W+1)'(s1_valid_ff)
                      + (QCNT_W+1)'(s2_valid_ff) + (QCNT_W+1)'(s3_valid_ff);
   assign full   = credit_used >= (QCNT_W+1)'(QUEUE_DEPTH);
   assign accept = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage 1: offset from origin
   logic                     s1_cmd_ff, s2_cmd_ff, s3_cmd_ff;
   logic [COL_W-1:0]         s1_col_ff, s2_col_ff, s3_col_ff;
   logic [ROW_W-1:0]         s1_row_ff, s2_row_ff, s3_row_ff;
   logic [ELEV_W-1:0]        s1_elev_ff, s2_elev_ff, s3_elev_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;

   assign s1_dx_in = DIFF_W'($signed(req_query_east)) - DIFF_W'($signed(origin_east_ff));
   assign s1_dy_in = DIFF_W'($signed(req_query_north)) - DIFF_W'($signed(origin_north_ff));

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= req_cmd;
         s1_col_ff  <= req_write_col;
         s1_row_ff  <= req_write_row;
         s1_elev_ff <= req_elevation_in;
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
      end
   end

   // stage 2: magnitudes and the zero cases
   logic [DIFF_W-1:0]  s2_ux_ff, s2_uy_ff;
   logic [RECIP_W-1:0] s2_rx_ff, s2_ry_ff;
   logic               s2_kx_ff, s2_ky_ff, s3_kx_ff, s3_ky_ff;

   always_ff @(posedge clock) begin
      s2_cmd_ff  <= s1_cmd_ff;
      s2_col_ff  <= s1_col_ff;
      s2_row_ff  <= s1_row_ff;
      s2_elev_ff <= s1_elev_ff;
      s2_ux_ff   <= s1_dx_ff[DIFF_W-1] ? DIFF_W'(-s1_dx_ff) : DIFF_W'(s1_dx_ff);
      s2_uy_ff   <= s1_dy_ff[DIFF_W-1] ? DIFF_W'(-s1_dy_ff) : DIFF_W'(s1_dy_ff);
      s2_rx_ff   <= cpm_x_ff[RECIP_W-1] ? RECIP_W'(-cpm_x_ff) : cpm_x_ff;
      s2_ry_ff   <= cpm_y_ff[RECIP_W-1] ? RECIP_W'(-cpm_y_ff) : cpm_y_ff;
      s2_kx_ff   <= (s1_dx_ff == '0) || (cpm_x_ff == '0)
                  || (s1_dx_ff[DIFF_W-1] != cpm_x_ff[RECIP_W-1]);
      s2_ky_ff   <= (s1_dy_ff == '0) || (cpm_y_ff == '0)
                  || (s1_dy_ff[DIFF_W-1] != cpm_y_ff[RECIP_W-1]);
   end

   // stage 3: split products
   logic [PH_W-1:0] s3_phx_ff, s3_phy_ff;
   logic [PL_W-1:0] s3_plx_ff, s3_ply_ff;

   always_ff @(posedge clock) begin
      s3_cmd_ff  <= s2_cmd_ff;
      s3_col_ff  <= s2_col_ff;
      s3_row_ff  <= s2_row_ff;
      s3_elev_ff <= s2_elev_ff;
      s3_kx_ff   <= s2_kx_ff;
      s3_ky_ff   <= s2_ky_ff;
      s3_phx_ff  <= PH_W'(s2_ux_ff[DIFF_W-1:LO_W]) * PH_W'(s2_rx_ff);
      s3_plx_ff  <= PL_W'(s2_ux_ff[LO_W-1:0]) * PL_W'(s2_rx_ff);
      s3_phy_ff  <= PH_W'(s2_uy_ff[DIFF_W-1:LO_W]) * PH_W'(s2_ry_ff);
      s3_ply_ff  <= PL_W'(s2_uy_ff[LO_W-1:0]) * PL_W'(s2_ry_ff);
   end

   // sum, clamp to grid, pick neighbors
   logic [TOT_W-1:0]       totx, toty;
   logic [TOT_W-SHIFT-1:0] vx, vy;
   logic [IDX_W-1:0]       limx, limy, fx, fy;
   logic [COL_W-1:0]       x0;
   logic [ROW_W-1:0]       y0;

   always_comb begin
      totx = {s3_phx_ff, LO_W'(0)} + TOT_W'(s3_plx_ff);
      toty = {s3_phy_ff, LO_W'(0)} + TOT_W'(s3_ply_ff);
      vx   = totx[TOT_W-1:SHIFT];
      vy   = toty[TOT_W-1:SHIFT];
      limx = {cols_m1, FRAC_W'(0)};
      limy = {rows_m1, FRAC_W'(0)};
      if (s3_kx_ff) fx = '0;
      else if (vx > (TOT_W-SHIFT)'(limx)) fx = limx;
      else fx = vx[IDX_W-1:0];
      if (s3_ky_ff) fy = '0;
      else if (vy > (TOT_W-SHIFT)'(limy)) fy = limy;
      else fy = vy[IDX_W-1:0];
      x0 = fx[IDX_W-1:FRAC_W];
      y0 = fy[ROW_W+FRAC_W-1:FRAC_W];

      queue_entry.cmd  = s3_cmd_ff;
      queue_entry.tx   = fx[FRAC_W-1:0];
      queue_entry.ty   = fy[FRAC_W-1:0];
      queue_entry.elev = s3_elev_ff;
      if (s3_cmd_ff == CMD_WRITE) begin
         queue_entry.x0 = s3_col_ff;
         queue_entry.x1 = s3_col_ff;
         queue_entry.y0 = s3_row_ff;
         queue_entry.y1 = s3_row_ff;
      end else begin
         queue_entry.x0 = x0;
         queue_entry.x1 = (x0 == cols_m1) ? x0 : x0 + COL_W'(1);
         queue_entry.y0 = y0;
         queue_entry.y1 = (y0 == rows_m1) ? y0 : y0 + ROW_W'(1);
      end
   end

   assign queue_push = s3_valid_ff;

endmodule

FILE: rtl/gbs_back.sv
// gbs_back: four-bank elevation grid, bilinear blend pipeline and result FIFO.
// Depends on gbs_pkg.
module gbs_back import gbs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  gbs_entry_type     head,
   input  logic [QCNT_W-1:0] queue_count,
   output logic              queue_pop,
   input  logic              pop,
   output logic              empty,
   output logic [ELEV_W-1:0] rsp_elevation_out
);

   localparam int BANK_AW    = COL_W + ROW_W - 2;
   localparam int BANK_DEPTH = 1 << BANK_AW;
   localparam int OUT_DEPTH  = 8;
   localparam int OPTR_W     = $clog2(OUT_DEPTH);
   localparam int OCNT_W     = $clog2(OUT_DEPTH + 1);
   localparam int A_W        = ELEV_W + FRAC_W + 2;
   localparam int P_W        = A_W - FRAC_W + FRAC_W + 1;
   localparam int S_W        = A_W + FRAC_W + 2;

   logic b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff;
   logic [OCNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic [OCNT_W:0]   out_used;
   logic              out_pop;

   assign out_used = {1'b0, out_cnt_ff} + (OCNT_W+1)'(b1_valid_ff)
                   + (OCNT_W+1)'(b2_valid_ff) + (OCNT_W+1)'(b3_valid_ff)
                   + (OCNT_W+1)'(b4_valid_ff);
   assign queue_pop = (queue_count != '0) && (out_used < (OCNT_W+1)'(OUT_DEPTH));

   logic do_write, do_read;
   assign do_write = queue_pop && (head.cmd == CMD_WRITE);
   assign do_read  = queue_pop && (head.cmd == CMD_SAMPLE);

   // bank index is {row parity, column parity}
   logic [ELEV_W-1:0]  bank_mem [4][BANK_DEPTH];
   logic [ELEV_W-1:0]  rd_ff [4];
   logic [BANK_AW-1:0] rd_addr [4];
   logic [BANK_AW-1:0] wr_addr;
   logic [1:0]         wr_bank;

   always_comb begin
      logic [COL_W-1:0] c;
      logic [ROW_W-1:0] r;
      for (int b = 0; b < 4; b++) begin
         c = (head.x0[0] == b[0]) ? head.x0 : head.x1;
         r = (head.y0[0] == b[1]) ? head.y0 : head.y1;
         rd_addr[b] = {r[ROW_W-1:1], c[COL_W-1:1]};
      end
      wr_bank = {head.y0[0], head.x0[0]};
      wr_addr = {head.y0[ROW_W-1:1], head.x0[COL_W-1:1]};
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < 4; b++) begin
         if (do_write && wr_bank == 2'(b)) bank_mem[b][wr_addr] <= head.elev;
         rd_ff[b] <= bank_mem[b][rd_addr[b]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         b4_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= do_read;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         b4_valid_ff <= b3_valid_ff;
      end
   end

   // B1: neighbor select and blend in x
   logic              b1_x0p_ff, b1_x1p_ff, b1_y0p_ff, b1_y1p_ff;
   logic [FRAC_W-1:0] b1_tx_ff, b1_ty_ff, b2_ty_ff, b3_ty_ff;

   always_ff @(posedge clock) begin
      b1_x0p_ff <= head.x0[0];
      b1_x1p_ff <= head.x1[0];
      b1_y0p_ff <= head.y0[0];
      b1_y1p_ff <= head.y1[0];
      b1_tx_ff  <= head.tx;
      b1_ty_ff  <= head.ty;
   end

   logic signed [ELEV_W-1:0] v00, v10, v01, v11;
   logic signed [ELEV_W:0]   dif0, dif1;
   logic signed [ELEV_W-1:0] b2_v00_ff, b2_v01_ff;
   logic signed [A_W-1:0]    b2_m0_ff, b2_m1_ff;

   always_comb begin
      v00  = $signed(rd_ff[{b1_y0p_ff, b1_x0p_ff}]);
      v10  = $signed(rd_ff[{b1_y0p_ff, b1_x1p_ff}]);
      v01  = $signed(rd_ff[{b1_y1p_ff, b1_x0p_ff}]);
      v11  = $signed(rd_ff[{b1_y1p_ff, b1_x1p_ff}]);
      dif0 = (ELEV_W+1)'(v10) - (ELEV_W+1)'(v00);
      dif1 = (ELEV_W+1)'(v11) - (ELEV_W+1)'(v01);
   end

   always_ff @(posedge clock) begin
      b2_v00_ff <= v00;
      b2_v01_ff <= v01;
      b2_ty_ff  <= b1_ty_ff;
      b2_m0_ff  <= A_W'(dif0) * $signed(A_W'(b1_tx_ff));
      b2_m1_ff  <= A_W'(dif1) * $signed(A_W'(b1_tx_ff));
   end

   // B2: row values and their difference
   logic signed [A_W-1:0] row_a, row_b, b3_a_ff, b3_d_ff;

   always_comb begin
      row_a = (A_W'(b2_v00_ff) <<< FRAC_W) + b2_m0_ff;
      row_b = (A_W'(b2_v01_ff) <<< FRAC_W) + b2_m1_ff;
   end

   always_ff @(posedge clock) begin
      b3_a_ff  <= row_a;
      b3_d_ff  <= row_b - row_a;
      b3_ty_ff <= b2_ty_ff;
   end

   // B3: split blend in y
   logic signed [A_W-1:0]   b4_a_ff;
   logic signed [P_W-1:0]   b4_p_ff;
   logic [2*FRAC_W-1:0]     b4_e_ff;

   always_ff @(posedge clock) begin
      b4_a_ff <= b3_a_ff;
      b4_p_ff <= P_W'($signed(b3_d_ff[A_W-1:FRAC_W])) * $signed(P_W'(b3_ty_ff));
      b4_e_ff <= (2*FRAC_W)'(b3_d_ff[FRAC_W-1:0]) * (2*FRAC_W)'(b3_ty_ff);
   end

   // B4: round half up and saturate
   localparam logic [S_W-1:0] ROUND_HALF = S_W'(1) << (2*FRAC_W - 1);
   logic [S_W-1:0]                  sum;
   logic signed [S_W-2*FRAC_W-1:0]  rnd;
   logic [ELEV_W-1:0]               res;

   always_comb begin
      sum = (S_W'(b4_a_ff) << FRAC_W) + (S_W'(b4_p_ff) << FRAC_W)
          + S_W'(b4_e_ff) + ROUND_HALF;
      rnd = $signed(sum[S_W-1:2*FRAC_W]);
      if (rnd > (S_W-2*FRAC_W)'($signed(24'sh7F_FFFF))) res = 24'h7F_FFFF;
      else if (rnd < (S_W-2*FRAC_W)'($signed(24'sh80_0000))) res = 24'h80_0000;
      else res = rnd[ELEV_W-1:0];
   end

   // result FIFO
   logic [ELEV_W-1:0] out_mem_ff [OUT_DEPTH];
   logic [OPTR_W-1:0] owptr_ff, orptr_ff;

   assign empty   = (out_cnt_ff == '0);
   assign out_pop = pop && !empty;

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (b4_valid_ff && !out_pop) out_cnt_in = out_cnt_ff + OCNT_W'(1);
      else if (out_pop && !b4_valid_ff) out_cnt_in = out_cnt_ff - OCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owptr_ff   <= '0;
         orptr_ff   <= '0;
         out_cnt_ff <= '0;
      end else begin
         if (b4_valid_ff) owptr_ff <= owptr_ff + OPTR_W'(1);
         if (out_pop) orptr_ff <= orptr_ff + OPTR_W'(1);
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b4_valid_ff) out_mem_ff[owptr_ff] <= res;
   end

   assign rsp_elevation_out = out_mem_ff[orptr_ff];

endmodule

FILE: rtl/grid_bilinear_sampler.sv
// grid_bilinear_sampler: top level; front, queue and back.
// Depends on gbs_pkg, gbs_front, gbs_queue, gbs_back.
//
// Takes one word per cycle while full is low: a write stores one grid cell,
// a sample returns one bilinearly interpolated elevation. A sample passes
// 3 front index stages, the queue, a bank read and 4 blend stages before
// its result is ready. The grid sits in four banks split by column and row
// parity, so the four neighbors of a sample come out of a single read and
// a write uses one bank. Grid cells come up undefined after reset; there is
// no clearing pass. Writes and samples act in the order taken.
module grid_bilinear_sampler import gbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_cmd,
   input  logic [COL_W-1:0]      req_write_col,
   input  logic [ROW_W-1:0]      req_write_row,
   input  logic [ELEV_W-1:0]     req_elevation_in,
   input  logic [COORD_W-1:0]    req_query_east,
   input  logic [COORD_W-1:0]    req_query_north,
   output logic                  empty,
   input  logic                  pop,
   output logic [ELEV_W-1:0]     rsp_elevation_out
);

   logic              q_push, q_pop;
   gbs_entry_type     q_in, q_head;
   logic [QCNT_W-1:0] q_count;

   gbs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .full             (full),
      .req_cmd          (req_cmd),
      .req_write_col    (req_write_col),
      .req_write_row    (req_write_row),
      .req_elevation_in (req_elevation_in),
      .req_query_east   (req_query_east),
      .req_query_north  (req_query_north),
      .queue_count      (q_count),
      .queue_push       (q_push),
      .queue_entry      (q_in)
   );

   gbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .head       (q_head),
      .count      (q_count)
   );

   gbs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (q_head),
      .queue_count       (q_count),
      .queue_pop         (q_pop),
      .pop               (pop),
      .empty             (empty),
      .rsp_elevation_out (rsp_elevation_out)
   );

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
      else $error("queue overflow");

   a_queue_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_count != '0))
      else $error("queue underflow");

   a_full_when_queue_full: assert property (@(posedge clock) disable iff (reset)
      (q_count == QCNT_W'(QUEUE_DEPTH)) |-> full)
      else $error("input taken with queue full");

endmodule

FILE: tb/gbs_checker.sv
// gbs_checker: watches the word channels of grid_bilinear_sampler, predicts
// each sample's elevation and compares. Depends on gbs_pkg.
module gbs_checker import gbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  push,
   input  logic                  full,
   input  logic                  req_cmd,
   input  logic [COL_W-1:0]      req_write_col,
   input  logic [ROW_W-1:0]      req_write_row,
   input  logic [ELEV_W-1:0]     req_elevation_in,
   input  logic [COORD_W-1:0]    req_query_east,
   input  logic [COORD_W-1:0]    req_query_north,
   input  logic                  empty,
   input  logic                  pop,
   input  logic [ELEV_W-1:0]     rsp_elevation_out,
   output int                    errors,
   output int                    pending
);

   logic signed [ELEV_W-1:0]  grid_mem [0:MAX_COLS*MAX_ROWS-1];
   logic signed [COORD_W-1:0] org_e, org_n;
   logic signed [RECIP_W-1:0] cpm_x, cpm_y;
   logic [SIZE_W-1:0]         cols_cfg, rows_cfg;
   logic [ELEV_W-1:0]         elev_q [$];

   function automatic int eff_size(logic [SIZE_W-1:0] v, int mx);
      if (v == 0) return 1;
      if (v > mx) return mx;
      return v;
   endfunction

   function automatic longint grid_pos(logic signed [COORD_W-1:0] q,
                                       logic signed [COORD_W-1:0] o,
                                       logic signed [RECIP_W-1:0] r, int n);
      logic signed [COORD_W:0] d;
      logic [COORD_W:0]        ud;
      logic [RECIP_W-1:0]      ur;
      logic [COORD_W+RECIP_W:0] prod;
      logic [COORD_W+RECIP_W:0] v;
      longint                  lim;
      d = $signed({q[COORD_W-1], q}) - $signed({o[COORD_W-1], o});
      lim = longint'(n - 1) <<< FRAC_W;
      if (d == 0 || r == 0) return 0;
      if (d[COORD_W] != r[RECIP_W-1]) return 0;
      ud = d[COORD_W] ? -d : d;
      ur = r[RECIP_W-1] ? -r : r;
      prod = ud * ur;
      v = prod >> (32 - FRAC_W);
      if (v > lim) return lim;
      return longint'(v);
   endfunction

   function automatic logic [ELEV_W-1:0] blend(logic [COORD_W-1:0] qe,
                                                logic [COORD_W-1:0] qn);
      int     nc, nr, x0, y0, x1, y1;
      longint fx, fy, tx, ty, a, b, d, t, v00, v10, v01, v11;
      nc = eff_size(cols_cfg, MAX_COLS);
      nr = eff_size(rows_cfg, MAX_ROWS);
      fx = grid_pos(qe, org_e, cpm_x, nc);
      fy = grid_pos(qn, org_n, cpm_y, nr);
      x0 = int'(fx >>> FRAC_W);
      y0 = int'(fy >>> FRAC_W);
      tx = fx & ((64'sd1 <<< FRAC_W) - 1);
      ty = fy & ((64'sd1 <<< FRAC_W) - 1);
      x1 = (x0 + 1 < nc) ? x0 + 1 : nc - 1;
      y1 = (y0 + 1 < nr) ? y0 + 1 : nr - 1;
      v00 = grid_mem[y0*MAX_COLS + x0];
      v10 = grid_mem[y0*MAX_COLS + x1];
      v01 = grid_mem[y1*MAX_COLS + x0];
      v11 = grid_mem[y1*MAX_COLS + x1];
      a = (v00 <<< FRAC_W) + (v10 - v00) * tx;
      b = (v01 <<< FRAC_W) + (v11 - v01) * tx;
      d = b - a;
      t = ((a <<< FRAC_W) + d * ty + (64'sd1 <<< (2*FRAC_W - 1))) >>> (2*FRAC_W);
      if (t > 8388607) t = 8388607;
      if (t < -8388608) t = -8388608;
      return t[ELEV_W-1:0];
   endfunction

   task automatic report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   assign pending = elev_q.size();

   always @(posedge clock) begin
      if (reset) begin
         org_e    <= '0;
         org_n    <= '0;
         cpm_x    <= 32'sd16777216;
         cpm_y    <= 32'sd16777216;
         cols_cfg <= 9'd256;
         rows_cfg <= 9'd256;
         errors = 0;
         elev_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ORIGIN_EAST:  org_e    <= csr_write_data;
               CSR_ORIGIN_NORTH: org_n    <= csr_write_data;
               CSR_CPM_X:        cpm_x    <= csr_write_data[RECIP_W-1:0];
               CSR_CPM_Y:        cpm_y    <= csr_write_data[RECIP_W-1:0];
               CSR_GRID_COLS:    cols_cfg <= csr_write_data[SIZE_W-1:0];
               CSR_GRID_ROWS:    rows_cfg <= csr_write_data[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (push && !full) begin
            if (req_cmd == CMD_WRITE)
               grid_mem[req_write_row*MAX_COLS + req_write_col] = req_elevation_in;
            else
               elev_q.push_back(blend(req_query_east, req_query_north));
         end
         if (pop && !empty) begin
            if (elev_q.size() == 0)
               report($sformatf("unexpected word %h", rsp_elevation_out));
            else if (elev_q[0] !== rsp_elevation_out) begin
               report($sformatf("elevation_out got %h want %h",
                                rsp_elevation_out, elev_q[0]));
               void'(elev_q.pop_front());
            end else
               void'(elev_q.pop_front());
         end
      end
   end

endmodule

FILE: tb/testbench.sv
// testbench: drives grid_bilinear_sampler through register settings, grid
// fills and sample streams. Depends on gbs_pkg, grid_bilinear_sampler, gbs_checker.
module testbench;
   import gbs_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   logic                  push, full, empty, pop;
   logic                  req_cmd;
   logic [COL_W-1:0]      req_write_col;
   logic [ROW_W-1:0]      req_write_row;
   logic [ELEV_W-1:0]     req_elevation_in;
   logic [COORD_W-1:0]    req_query_east, req_query_north;
   logic [ELEV_W-1:0]     rsp_elevation_out;
   int                    errors, pending;
   int                    idle_cycles;
   int                    burst_left;
   bit                    long_hold;
   bit                    written [MAX_COLS*MAX_ROWS];

   longint ph_oe, ph_on, ph_rx, ph_ry;
   int     ph_nc, ph_nr;

   grid_bilinear_sampler u_dut (.*);
   gbs_checker u_chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      pop = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            pop <= 0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end
         case ((idle_cycles + $urandom_range(0, 3)) % 4 == 0 ? $urandom_range(0, 2) : 0)
            0: pop <= 1;
            1: pop <= ($urandom_range(0, 3) != 0);
            default: pop <= 0;
         endcase
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || csr_write_enable || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 20000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send(logic cmd, logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                       logic [ELEV_W-1:0] elev, logic [COORD_W-1:0] qe,
                       logic [COORD_W-1:0] qn);
      if (burst_left == 0) begin
         int gap;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            push <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      push             <= 1;
      req_cmd          <= cmd;
      req_write_col    <= col;
      req_write_row    <= row;
      req_elevation_in <= elev;
      req_query_east   <= qe;
      req_query_north  <= qn;
      do @(posedge clock); while (full);
   endtask

   task automatic write_cell(int col, int row, logic [ELEV_W-1:0] v);
      written[row*MAX_COLS + col] = 1'b1;
      send(CMD_WRITE, COL_W'(col), ROW_W'(row), v,
           COORD_W'({$urandom, $urandom}), COORD_W'({$urandom, $urandom}));
   endtask

   task automatic sample(longint qe, longint qn);
      send(CMD_SAMPLE, COL_W'($urandom), ROW_W'($urandom), ELEV_W'($urandom),
           qe[COORD_W-1:0], qn[COORD_W-1:0]);
   endtask

   task automatic csr_wr(logic [CSR_IDX_W-1:0] idx, longint v);
      csr_write_enable <= 1;
      csr_index        <= idx;
      csr_write_data   <= v[CSR_DATA_W-1:0];
      @(posedge clock);
   endtask

   task automatic drain;
      push <= 0;
      burst_left = 0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic int eff(int v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
   endfunction

   function automatic longint coord_near(longint o, longint r, int n);
      longint cell_q, off;
      if (r == 0 || $urandom_range(0, 9) == 0)
         return {$urandom, $urandom};
      cell_q = (64'sd1 <<< 32) / (r < 0 ? -r : r);
      off = longint'($urandom_range(0, 1000 * (n + 4))) * cell_q / 1000 - 2 * cell_q;
      if ($urandom_range(0, 7) == 0) off = off - off % cell_q;
      return r < 0 ? o - off : o + off;
   endfunction

   // cells already written by earlier phases keep their values
   task automatic start_phase(longint oe, longint on, longint rx, longint ry,
                              int gc, int gr);
      drain();
      csr_wr(CSR_ORIGIN_EAST, oe);
      csr_wr(CSR_ORIGIN_NORTH, on);
      csr_wr(CSR_CPM_X, rx);
      csr_wr(CSR_CPM_Y, ry);
      csr_wr(CSR_GRID_COLS, gc);
      csr_wr(CSR_GRID_ROWS, gr);
      csr_write_enable <= 0;
      ph_oe = oe; ph_on = on; ph_rx = rx; ph_ry = ry;
      ph_nc = eff(gc); ph_nr = eff(gr);
      for (int y = 0; y < ph_nr; y++)
         for (int x = 0; x < ph_nc; x++)
            if (!written[y*MAX_COLS + x])
               write_cell(x, y, ELEV_W'($urandom));
   endtask

   task automatic random_items(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 3)
            write_cell($urandom_range(0, 255), $urandom_range(0, 255),
                       ELEV_W'($urandom));
         else
            sample(coord_near(ph_oe, ph_rx, ph_nc), coord_near(ph_on, ph_ry, ph_nr));
      end
   endtask

   initial begin
      reset = 1;
      long_hold = 0;
      burst_left = 0;
      csr_write_enable = 0;
      csr_index = '0;
      csr_write_data = '0;
      push = 0;
      req_cmd = CMD_WRITE;
      req_write_col = '0;
      req_write_row = '0;
      req_elevation_in = '0;
      req_query_east = '0;
      req_query_north = '0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: 2x2 grid at unit spacing with extreme elevations
      start_phase(0, 0, 64'sd1 <<< 24, 64'sd1 <<< 24, 2, 2);
      write_cell(0, 0, 24'h800000);
      write_cell(1, 0, 24'h7fffff);
      write_cell(0, 1, 24'h7fffff);
      write_cell(1, 1, 24'h800000);
      sample(0, 0);
      sample(-256, -256);
      sample(256, 0);
      sample(128, 128);
      sample(64, 192);
      sample(100000, 100000);
      sample(64'sh7fffffffff, 64'sh7fffffffff);
      sample(-64'sh8000000000, 64'sh7fffffffff);
      write_cell(255, 255, 24'h123456);
      write_cell(0, 0, 24'h000000);
      sample(1, 255);
      sample(255, 1);

      start_phase(0, 0, 0, 0, 3, 3);
      sample(12345, -999);
      sample(-64'sh8000000000, 64'sh7fffffffff);

      start_phase(64'sh7fffffffff, -64'sh8000000000, 32'sh7fffffff, -32'sh80000000, 4, 4);
      random_items(40);

      start_phase(1000, -5000, 64'sd1 <<< 24, -(64'sd1 <<< 23), 48, 1);
      random_items(25);

      start_phase(-77777, 4242, 64'sd3 <<< 22, 64'sd1 <<< 25, 0, 511);
      random_items(25);

      start_phase(64'sd1 <<< 36, -(64'sd1 <<< 35), -(64'sd5 <<< 22), 64'sd1 <<< 20, 7, 5);
      long_hold = 1;
      random_items(60);
      drain();

      start_phase($urandom - 64'sd2147483648, $urandom - 64'sd2147483648,
                  $urandom_range(1 << 16, 1 << 28),
                  -longint'($urandom_range(1 << 16, 1 << 28)), 8, 8);
      random_items(40);

      start_phase(0, 0, 64'sd1 <<< 24, 64'sd1 <<< 24, 511, 0);
      random_items(25);

      start_phase(-123456, 654321, 64'sd1 <<< 26, 64'sd1 <<< 24, 2, 9);
      random_items(25);

      start_phase(0, 0, 64'sd1 <<< 24, 64'sd1 <<< 24, 1, 1);
      random_items(10);

      drain();
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
